/* design/nll_pkg.sv */
// package for the nonlinear ladder lowpass: widths, register codes, sequencer states
package nll_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 24;
    localparam int FRACTION_BITS_DEF = 20;
    localparam int CFG_WIDTH         = 18;
    localparam int CFG_INDEX_WIDTH   = 1;
    localparam int COEF_BITS         = 17;
    localparam int FEEDBACK_BITS     = 16;

    localparam logic [CFG_WIDTH-1:0] CUTOFF_RESET    = 18'd17146;
    localparam logic [CFG_WIDTH-1:0] RESONANCE_RESET = 18'd0;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CUTOFF    = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RESONANCE = 1'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FB_MUL,
        ST_FB_ADD,
        ST_SH_CHK,
        ST_SH_SQ,
        ST_SH_NUM,
        ST_SH_DIV,
        ST_SH_WAIT,
        ST_SH_RET,
        ST_ST_MUL,
        ST_ST_ADD,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        SEL_X,
        SEL_Y4,
        SEL_N1,
        SEL_N2,
        SEL_N3
    } t_sel;

endpackage

/* design/nll_in_if.sv */
// input item channel: sample and clear flag
interface nll_in_if #(
    parameter int SAMPLE_WIDTH = nll_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           clear_state;

    modport source (output valid, output sample_in, output clear_state, input ready);
    modport sink   (input valid, input sample_in, input clear_state, output ready);
endinterface

/* design/nll_out_if.sv */
// result item channel: filtered sample
interface nll_out_if #(
    parameter int SAMPLE_WIDTH = nll_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

/* design/nll_div.sv */
// iterative restoring divider, one quotient bit per cycle
module nll_div #(
    parameter int DW   = 48,
    parameter int DENW = 27,
    parameter int QB   = 22
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [DW-1:0]   i_dividend,
    input  logic [DENW-1:0] i_divisor,
    output logic            o_done,
    output logic [QB-1:0]   o_quot
);
    localparam int CW = $clog2(QB + 1);

    logic [DENW:0]   r_rem;
    logic [QB-1:0]   r_dsh;
    logic [QB-1:0]   r_q;
    logic [DENW-1:0] r_den;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [DENW:0]   trial;
    logic            qbit;

    always_comb begin
        trial = {r_rem[DENW-1:0], r_dsh[QB-1]};
        qbit  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= (DENW+1)'(i_dividend >> QB);
            r_dsh <= i_dividend[QB-1:0];
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= qbit ? (trial - {1'b0, r_den}) : trial;
            r_dsh <= r_dsh << 1;
            r_q   <= {r_q[QB-2:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

/* design/nonlinear_ladder_lowpass_core.sv */
// top level: four-pole nonlinear ladder lowpass on one shared multiplier and divider
// each item takes five tanh shapings, each one bit-serial divide for FRACTION_BITS+2
//   quotient bits; a shaping argument beyond +-3 skips the divide
// clear item: goes from idle straight to the finish state and posts a zero result
// flow: one item at a time, ready only in idle; the finish state waits for a free result register
// reset: synchronous active low, clears stage state, sequencer, result valid and
//   loads register reset values
module nonlinear_ladder_lowpass_core #(
    parameter int SAMPLE_WIDTH  = nll_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = nll_pkg::FRACTION_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [nll_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_idx,
    input  logic [nll_pkg::CFG_WIDTH-1:0]         i_cfg_wdata,
    nll_in_if.sink                                i_in,
    nll_out_if.source                             o_out
);
    import nll_pkg::*;

    localparam int W    = SAMPLE_WIDTH;
    localparam int F    = FRACTION_BITS;
    // multiplier operand width: covers samples and the shaping numerator term
    localparam int MW   = (W > F + 8) ? W : F + 8;
    localparam int PW   = 2 * MW;
    // working width for sums before saturation
    localparam int AW   = MW + 4;
    // divider sizing: numerator below 2^(2F+7), denominator below 2^(F+7)
    localparam int DW   = 2 * F + 8;
    localparam int DENW = F + 7;
    localparam int QB   = F + 2;
    localparam int SHMX = (F > COEF_BITS) ? F : COEF_BITS;
    localparam int SHW  = $clog2(SHMX + 1);

    localparam logic signed [AW-1:0] ONE   = AW'(1) << F;
    localparam logic signed [AW-1:0] THREE = AW'(3) << F;
    localparam logic signed [AW-1:0] FOUR  = AW'(4) << F;
    localparam logic signed [AW-1:0] K27   = AW'(27) << F;
    localparam logic signed [AW-1:0] SMAX  = (AW'(1) << (W - 1)) - AW'(1);
    localparam logic signed [AW-1:0] SMIN  = ~SMAX;

    function automatic logic signed [W-1:0] sat_w(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] t;
        t = v;
        if (t > SMAX) t = SMAX;
        if (t < SMIN) t = SMIN;
        return t[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] clamp4(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] t;
        t = v;
        if (t > FOUR) t = FOUR;
        if (t < -FOUR) t = -FOUR;
        return sat_w(t);
    endfunction

    // configuration registers
    logic [CFG_WIDTH-1:0] r_cut;
    logic [CFG_WIDTH-1:0] r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut <= CUTOFF_RESET;
            r_res <= RESONANCE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CUTOFF:    r_cut <= i_cfg_wdata;
                REG_RESONANCE: r_res <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer and datapath registers
    t_state                r_state, n_state;
    t_sel                  r_sel;
    logic [1:0]            r_k;
    logic signed [W-1:0]   r_y [4];      // stage values
    logic signed [AW-1:0]  r_t [3];      // shaped stage results
    logic signed [W-1:0]   r_n [4];      // unclamped stage results
    logic signed [AW-1:0]  r_tx;         // shaped feedback-reduced input
    logic signed [AW-1:0]  r_ty4;        // shaped fourth stage
    logic signed [W-1:0]   r_smp;
    logic signed [AW-1:0]  r_v;          // shaper argument
    logic signed [AW-1:0]  r_sq;
    logic [DENW-1:0]       r_den;
    logic                  r_neg;
    logic signed [AW-1:0]  r_s;          // shaper result
    logic signed [PW-1:0]  r_p;          // product register
    logic signed [W-1:0]   r_out;
    logic                  r_ov;

    // shared multiplier operands
    logic signed [MW-1:0]  ma, mb;
    logic signed [AW-1:0]  diff_a, diff_b, diff;

    // rounding of the product, ties away from zero
    logic [SHW-1:0]        sh;
    logic                  p_neg;
    logic [PW-1:0]         p_mag, p_sum, p_rmag;
    logic signed [PW-1:0]  p_rnd;
    logic signed [AW-1:0]  rnd_aw;

    // divider hookup
    logic                  div_start, div_done;
    logic [DW-1:0]         div_dividend;
    logic [QB-1:0]         div_quot;

    logic accept, out_take, fin_go;

    assign accept   = i_in.valid && i_in.ready;
    assign out_take = r_ov && o_out.ready;
    assign fin_go   = !r_ov || o_out.ready;

    always_comb begin
        case (r_k)
            2'd0:    diff_a = r_tx;
            2'd1:    diff_a = r_t[0];
            2'd2:    diff_a = r_t[1];
            default: diff_a = r_t[2];
        endcase
        case (r_k)
            2'd0:    diff_b = r_t[0];
            2'd1:    diff_b = r_t[1];
            2'd2:    diff_b = r_t[2];
            default: diff_b = r_ty4;
        endcase
        diff = diff_a - diff_b;
    end

    always_comb begin
        ma = '0;
        mb = '0;
        case (r_state)
            ST_FB_MUL: begin
                ma = MW'($signed({1'b0, r_res}));
                mb = MW'(r_y[3]);
            end
            ST_SH_CHK: begin
                ma = r_v[MW-1:0];
                mb = r_v[MW-1:0];
            end
            ST_SH_NUM: begin
                ma = r_v[MW-1:0];
                mb = MW'(K27 + r_sq);
            end
            ST_ST_MUL: begin
                ma = MW'($signed({1'b0, r_cut}));
                mb = diff[MW-1:0];
            end
            default: ;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_FB_ADD: sh = SHW'(FEEDBACK_BITS);
            ST_ST_ADD: sh = SHW'(COEF_BITS);
            default:   sh = SHW'(F);
        endcase
        p_neg  = r_p[PW-1];
        p_mag  = p_neg ? PW'(-r_p) : PW'(r_p);
        p_sum  = p_mag + (PW'(1) << (sh - SHW'(1)));
        p_rmag = p_sum >> sh;
        p_rnd  = p_neg ? -$signed(p_rmag) : $signed(p_rmag);
        rnd_aw = p_rnd[AW-1:0];
    end

    assign div_start    = (r_state == ST_SH_DIV);
    assign div_dividend = p_mag[DW-1:0] + DW'(r_den >> 1);

    nll_div #(
        .DW   (DW),
        .DENW (DENW),
        .QB   (QB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = i_in.clear_state ? ST_FIN : ST_FB_MUL;
            end
            ST_FB_MUL:  n_state = ST_FB_ADD;
            ST_FB_ADD:  n_state = ST_SH_CHK;
            ST_SH_CHK: begin
                // outside +-3 the shape is a constant
                if (r_v > THREE || r_v < -THREE) n_state = ST_SH_RET;
                else n_state = ST_SH_SQ;
            end
            ST_SH_SQ:   n_state = ST_SH_NUM;
            ST_SH_NUM:  n_state = ST_SH_DIV;
            ST_SH_DIV:  n_state = ST_SH_WAIT;
            ST_SH_WAIT: begin
                if (div_done) n_state = ST_SH_RET;
            end
            ST_SH_RET: begin
                unique case (r_sel)
                    SEL_Y4:  n_state = ST_ST_MUL;
                    SEL_N3:  n_state = ST_FIN;
                    default: n_state = ST_SH_CHK;
                endcase
            end
            ST_ST_MUL:  n_state = ST_ST_ADD;
            ST_ST_ADD:  n_state = (r_k == 2'd3) ? ST_SH_CHK : ST_ST_MUL;
            ST_FIN: begin
                if (fin_go) n_state = ST_IDLE;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    assign i_in.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // stage state, cleared by reset and by a clear item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_y[i] <= '0;
                r_n[i] <= '0;
            end
            for (int i = 0; i < 3; i++) r_t[i] <= '0;
            r_ov <= 1'b0;
        end else begin
            // a new result may be posted in the cycle the old one is taken
            if (r_state == ST_FIN && fin_go) r_ov <= 1'b1;
            else if (out_take)               r_ov <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept && i_in.clear_state) begin
                        for (int i = 0; i < 4; i++) begin
                            r_y[i] <= '0;
                            r_n[i] <= '0;
                        end
                        for (int i = 0; i < 3; i++) r_t[i] <= '0;
                    end
                end
                ST_SH_RET: begin
                    case (r_sel)
                        SEL_N1:  r_t[0] <= r_s;
                        SEL_N2:  r_t[1] <= r_s;
                        SEL_N3:  r_t[2] <= r_s;
                        default: ;
                    endcase
                end
                ST_ST_ADD: r_n[r_k] <= sat_w(AW'(r_y[r_k]) + rnd_aw);
                ST_FIN: begin
                    if (fin_go) begin
                        for (int i = 0; i < 4; i++) r_y[i] <= clamp4(AW'(r_n[i]));
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_smp <= i_in.sample_in;
                r_k   <= 2'd0;
            end
            ST_FB_MUL: r_p <= ma * mb;
            ST_FB_ADD: begin
                r_v   <= AW'(sat_w(AW'(r_smp) - rnd_aw));
                r_sel <= SEL_X;
            end
            ST_SH_CHK: begin
                r_p <= ma * mb;
                if (r_v > THREE)       r_s <= ONE;
                else if (r_v < -THREE) r_s <= -ONE;
            end
            ST_SH_SQ:  r_sq <= rnd_aw;
            ST_SH_NUM: begin
                r_p   <= ma * mb;
                r_den <= DENW'(K27 + AW'(9) * r_sq);
            end
            ST_SH_DIV: r_neg <= p_neg;
            ST_SH_WAIT: begin
                if (div_done) r_s <= r_neg ? -AW'(div_quot) : AW'(div_quot);
            end
            ST_SH_RET: begin
                case (r_sel)
                    SEL_X: begin
                        r_tx  <= r_s;
                        r_v   <= AW'(r_y[3]);
                        r_sel <= SEL_Y4;
                    end
                    SEL_Y4: r_ty4 <= r_s;
                    SEL_N1: begin
                        r_v   <= AW'(r_n[1]);
                        r_sel <= SEL_N2;
                    end
                    SEL_N2: begin
                        r_v   <= AW'(r_n[2]);
                        r_sel <= SEL_N3;
                    end
                    default: ;
                endcase
            end
            ST_ST_MUL: r_p <= ma * mb;
            ST_ST_ADD: begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    // first unclamped stage was written on an earlier step
                    r_v   <= AW'(r_n[0]);
                    r_sel <= SEL_N1;
                end
            end
            ST_FIN: begin
                if (fin_go) r_out <= clamp4(AW'(r_n[3]));
            end
            default: ;
        endcase
    end

    assign o_out.valid      = r_ov;
    assign o_out.sample_out = r_out;

    // a divide result is only ever awaited in the wait state
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_SH_WAIT))
        else $error("divider finished outside wait state");

    // an accepted item always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != ST_IDLE))
        else $error("sequencer stayed idle after accepting an item");

    // finishing loads the result register
    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && fin_go) |=> (r_ov && r_state == ST_IDLE))
        else $error("result not posted on finish");

    // the divider is never restarted while a result is pending in the shaper
    a_start_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> (r_state == ST_SH_WAIT && !div_start))
        else $error("divider started twice");
endmodule

/* bench/tb_top.sv */
// testbench for the nonlinear ladder lowpass: bit-exact prediction, random idling, backpressure
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import nll_pkg::*;

    localparam int SW = SAMPLE_WIDTH_DEF;
    localparam int FB = FRACTION_BITS_DEF;
    localparam longint SMAX = (64'sd1 <<< (SW - 1)) - 1;
    localparam longint SMIN = -(64'sd1 <<< (SW - 1));
    localparam longint ONE  = 64'sd1 <<< FB;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_idx = REG_CUTOFF;
    logic [CFG_WIDTH-1:0] i_cfg_wdata = '0;

    nll_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
    nll_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

    nonlinear_ladder_lowpass_core #(.SAMPLE_WIDTH(SW), .FRACTION_BITS(FB)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model of the filter: registers and the seven state values
    longint cutoff_gain, feedback_gain;
    longint ladder_y [4];
    longint ladder_t [3];
    logic signed [SW-1:0] pending_samples [$];
    int errors = 0;
    int holdoff_req = 0;

    function automatic longint round_shift(longint v, int s);
        longint half;
        half = 64'sd1 <<< (s - 1);
        if (v >= 0) return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function automatic longint sat_w(longint v);
        if (v > SMAX) return SMAX;
        if (v < SMIN) return SMIN;
        return v;
    endfunction

    // rational tanh, hard limited beyond +-3
    function automatic longint tanh_approx(longint v);
        longint sq, num, den, mag, q;
        if (v > 3 * ONE) return ONE;
        if (v < -3 * ONE) return -ONE;
        sq  = round_shift(v * v, FB);
        num = v * (27 * ONE + sq);
        den = 27 * ONE + 9 * sq;
        mag = num < 0 ? -num : num;
        q   = (mag + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint clamp_four(longint v);
        if (v > 4 * ONE) v = 4 * ONE;
        if (v < -4 * ONE) v = -4 * ONE;
        return sat_w(v);
    endfunction

    function automatic logic signed [SW-1:0] ladder_step(logic signed [SW-1:0] s, logic clr);
        longint x, n [4];
        if (clr) begin
            foreach (ladder_y[i]) ladder_y[i] = 0;
            foreach (ladder_t[i]) ladder_t[i] = 0;
            return '0;
        end
        x = sat_w(longint'(s) - round_shift(feedback_gain * ladder_y[3], FEEDBACK_BITS));
        n[0] = sat_w(ladder_y[0] +
                     round_shift(cutoff_gain * (tanh_approx(x) - ladder_t[0]), COEF_BITS));
        n[1] = sat_w(ladder_y[1] +
                     round_shift(cutoff_gain * (ladder_t[0] - ladder_t[1]), COEF_BITS));
        n[2] = sat_w(ladder_y[2] +
                     round_shift(cutoff_gain * (ladder_t[1] - ladder_t[2]), COEF_BITS));
        n[3] = sat_w(ladder_y[3] +
                     round_shift(cutoff_gain * (ladder_t[2] - tanh_approx(ladder_y[3])), COEF_BITS));
        for (int i = 0; i < 3; i++) ladder_t[i] = tanh_approx(n[i]);
        for (int i = 0; i < 4; i++) ladder_y[i] = clamp_four(n[i]);
        return ladder_y[3][SW-1:0];
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // result side: random stalls plus a requested long holdoff
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (holdoff_req > 0) begin
            stall_left = holdoff_req;
            holdoff_req = 0;
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else begin
            stall_left = gap_len();
            out_ch.ready <= (stall_left == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_samples.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, out_ch.sample_out);
            end else begin
                logic signed [SW-1:0] exp_s;
                exp_s = pending_samples.pop_front();
                if (out_ch.sample_out !== exp_s) begin
                    errors++;
                    $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                             $time, exp_s, out_ch.sample_out);
                end
            end
        end
    end

    task automatic send_item(logic signed [SW-1:0] s, logic clr);
        int g;
        in_ch.valid <= 1'b1;
        in_ch.sample_in <= s;
        in_ch.clear_state <= clr;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_samples.push_back(ladder_step(s, clr));
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
        in_ch.valid <= 1'b0;
        wait (pending_samples.size() == 0);
        @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_CUTOFF) cutoff_gain = val;
        else feedback_gain = val;
    endtask

    function automatic logic signed [SW-1:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return SW'($urandom());
            1: return SW'($signed(SW'($urandom_range(0, 2 * ONE))) - ONE);
            2: return SW'($signed(SW'($urandom_range(0, 8 * ONE))) - 4 * ONE);
            default: return SW'($signed(SW'($urandom_range(0, 256))) - 128);
        endcase
    endfunction

    // extremes, clears, saturation with strong feedback and register extremes
    task automatic test_directed();
        write_reg(REG_CUTOFF, 18'h3FFFF);
        write_reg(REG_RESONANCE, 18'd249037);
        send_item(SW'(SMAX), 1'b0);
        send_item(SW'(SMAX), 1'b0);
        send_item(SW'(SMIN), 1'b0);
        send_item(SW'(SMIN), 1'b0);
        send_item(SW'(3 * ONE), 1'b0);
        send_item(SW'(3 * ONE + 1), 1'b0);
        send_item(SW'(-3 * ONE), 1'b0);
        send_item(SW'(-3 * ONE - 1), 1'b0);
        send_item(SW'(SMAX), 1'b1);
        send_item(SW'(0), 1'b0);
        send_item(SW'(-1), 1'b0);
        send_item(SW'(1), 1'b0);
        write_reg(REG_CUTOFF, 18'd0);
        write_reg(REG_RESONANCE, 18'h3FFFF);
        send_item(SW'(SMAX), 1'b0);
        send_item(SW'(SMIN), 1'b0);
        send_item(SW'(-1), 1'b1);
        write_reg(REG_CUTOFF, 18'd17146);
        write_reg(REG_RESONANCE, 18'd0);
        for (int i = 0; i < 6; i++) send_item(SW'(ONE), 1'b0);
    endtask

    // random items over several register settings
    task automatic test_random(int n_items);
        for (int i = 0; i < n_items; i++) begin
            if (i % 100 == 0) begin
                write_reg(REG_CUTOFF, CFG_WIDTH'($urandom_range(0, 3) == 0 ? $urandom()
                                                                 : $urandom_range(0, 40000)));
                write_reg(REG_RESONANCE, CFG_WIDTH'($urandom_range(0, 4) == 0 ? $urandom()
                                                                 : $urandom_range(0, 249037)));
            end
            send_item(rand_sample(), $urandom_range(0, 29) == 0);
        end
    endtask

    // long receiver holdoff while items keep coming, so the input stalls
    task automatic test_backpressure();
        in_ch.valid <= 1'b0;
        wait (pending_samples.size() == 0);
        holdoff_req = 800;
        for (int i = 0; i < 8; i++) send_item(rand_sample(), 1'b0);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.sample_in = '0;
        in_ch.clear_state = 1'b0;
        cutoff_gain = CUTOFF_RESET;
        feedback_gain = RESONANCE_RESET;
        foreach (ladder_y[i]) ladder_y[i] = 0;
        foreach (ladder_t[i]) ladder_t[i] = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(500);
        test_backpressure();
        test_random(500);
        in_ch.valid <= 1'b0;
        wait (pending_samples.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
